### rtl/core/qcap_pkg.sv
// ----------------------------------------------------------------------------
// qcap_pkg: shared types and constants of the cascaded attitude PID core
// Holds the fixed-point widths, the register map, the sequencer states and
// the schedule of gain products that the shared multiplier works through.
// ----------------------------------------------------------------------------
package qcap_pkg;

  // Field and arithmetic widths.
  localparam int SAMPLE_W       = 16;
  localparam int MOTOR_W        = 16;
  localparam int GAIN_W         = 32;
  localparam int INT_W          = 18;
  localparam int INTEGRAL_LIMIT = 300;
  localparam int MOTOR_MAX      = 65535;

  // The multiplier takes one 18-bit digit of an operand magnitude per cycle.
  localparam int DIG_W   = 18;
  localparam int NUM_DIG = 2;
  localparam int MAG_W   = DIG_W * NUM_DIG;
  localparam int PROD_W  = GAIN_W + DIG_W;
  localparam int PACC_W  = GAIN_W + MAG_W;
  localparam int FRAC_W  = 16;
  localparam int TERM_W  = PACC_W - FRAC_W;
  localparam int ACC_W   = 54;
  localparam int OPS_W   = 37;
  localparam int MIX_W   = 56;

  // Product schedule.
  localparam int NUM_TERMS  = 13;
  localparam int TERM_IDX_W = 4;
  localparam int LAST_OUTER = 6;

  // Register port.
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;
  localparam int REG_LSB = 2;

  localparam logic [GAIN_W-1:0] RST_TILT_OUTER_KP = 32'd13107200;
  localparam logic [GAIN_W-1:0] RST_TILT_OUTER_KI = 32'd0;
  localparam logic [GAIN_W-1:0] RST_TILT_OUTER_KD = 32'd0;
  localparam logic [GAIN_W-1:0] RST_YAW_OUTER_KP  = 32'd98304;
  localparam logic [GAIN_W-1:0] RST_TILT_INNER_KP = 32'd2621;
  localparam logic [GAIN_W-1:0] RST_TILT_INNER_KD = 32'd131;
  localparam logic [GAIN_W-1:0] RST_YAW_INNER_KP  = 32'd3015;
  localparam logic [GAIN_W-1:0] RST_YAW_INNER_KD  = 32'd786;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic        [MOTOR_W-1:0]  motor_t;
  typedef logic        [GAIN_W-1:0]   gain_t;
  typedef logic signed [INT_W-1:0]    integ_t;
  typedef logic signed [INT_W:0]      isum_t;
  typedef logic        [DIG_W-1:0]    dig_t;
  typedef logic        [MAG_W-1:0]    mag_t;
  typedef logic        [PROD_W-1:0]   prod_t;
  typedef logic        [PACC_W-1:0]   pacc_t;
  typedef logic        [TERM_W-1:0]   term_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef logic signed [OPS_W-1:0]    opsum_t;
  typedef logic signed [MIX_W-1:0]    mix_t;
  typedef logic [TERM_IDX_W-1:0]      tidx_t;

  typedef enum logic [2:0] {
    REG_TILT_OUTER_KP,
    REG_TILT_OUTER_KI,
    REG_TILT_OUTER_KD,
    REG_YAW_OUTER_KP,
    REG_TILT_INNER_KP,
    REG_TILT_INNER_KD,
    REG_YAW_INNER_KP,
    REG_YAW_INNER_KD
  } reg_idx_t;

  typedef enum logic [1:0] {
    AXIS_PITCH,
    AXIS_ROLL,
    AXIS_YAW
  } axis_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_FIN,
    ST_OPND1,
    ST_OPND2,
    ST_MIX1,
    ST_MIX2
  } state_t;

  typedef struct packed {
    reg_idx_t gain;
    axis_t    axis;
    logic     sh17;
    logic     two_dig;
  } term_info_t;

  typedef struct packed {
    logic acc_en;
    logic acc_hi;
    logic sh17;
  } mac_ctrl_t;

  // One gain product per entry. Entries 0 to 6 form the angle loop, 7 to 12
  // the rate loop. Only the rate loop proportional terms need two digits.
  function automatic term_info_t term_info(input tidx_t idx);
    term_info_t ti;
    ti = '{gain: REG_TILT_OUTER_KP, axis: AXIS_PITCH, sh17: 1'b0, two_dig: 1'b0};
    unique case (idx)
      4'd0:  ti.gain = REG_TILT_OUTER_KP;
      4'd1:  ti.gain = REG_TILT_OUTER_KI;
      4'd2:  ti.gain = REG_TILT_OUTER_KD;
      4'd3:  begin
        ti.gain = REG_TILT_OUTER_KP;
        ti.axis = AXIS_ROLL;
      end
      4'd4:  begin
        ti.gain = REG_TILT_OUTER_KI;
        ti.axis = AXIS_ROLL;
      end
      4'd5:  begin
        ti.gain = REG_TILT_OUTER_KD;
        ti.axis = AXIS_ROLL;
      end
      4'd6:  begin
        ti.gain = REG_YAW_OUTER_KP;
        ti.axis = AXIS_YAW;
      end
      4'd7:  begin
        ti.gain    = REG_TILT_INNER_KP;
        ti.sh17    = 1'b1;
        ti.two_dig = 1'b1;
      end
      4'd8:  begin
        ti.gain    = REG_TILT_INNER_KP;
        ti.axis    = AXIS_ROLL;
        ti.sh17    = 1'b1;
        ti.two_dig = 1'b1;
      end
      4'd9:  begin
        ti.gain    = REG_YAW_INNER_KP;
        ti.axis    = AXIS_YAW;
        ti.two_dig = 1'b1;
      end
      4'd10: ti.gain = REG_TILT_INNER_KD;
      4'd11: begin
        ti.gain = REG_TILT_INNER_KD;
        ti.axis = AXIS_ROLL;
      end
      4'd12: begin
        ti.gain = REG_YAW_INNER_KD;
        ti.axis = AXIS_YAW;
      end
      default: ;
    endcase
    return ti;
  endfunction

endpackage

### rtl/core/qcap_if.sv
// ----------------------------------------------------------------------------
// qcap_if: word channels of the cascaded attitude PID core
// Valid/ready channels for the sensor sample word and the motor command word.
// ----------------------------------------------------------------------------
interface qcap_in_if;
  logic              valid;
  logic              ready;
  qcap_pkg::sample_t pitch_angle;
  qcap_pkg::sample_t roll_angle;
  qcap_pkg::sample_t gyro_x;
  qcap_pkg::sample_t gyro_y;
  qcap_pkg::sample_t gyro_z;
  qcap_pkg::motor_t  throttle;

  modport source (
    output valid, pitch_angle, roll_angle, gyro_x, gyro_y, gyro_z, throttle,
    input  ready
  );
  modport sink (
    input  valid, pitch_angle, roll_angle, gyro_x, gyro_y, gyro_z, throttle,
    output ready
  );
endinterface

interface qcap_out_if;
  logic             valid;
  logic             ready;
  qcap_pkg::motor_t motor_0;
  qcap_pkg::motor_t motor_1;
  qcap_pkg::motor_t motor_2;
  qcap_pkg::motor_t motor_3;

  modport source (
    output valid, motor_0, motor_1, motor_2, motor_3,
    input  ready
  );
  modport sink (
    input  valid, motor_0, motor_1, motor_2, motor_3,
    output ready
  );
endinterface

### rtl/core/qcap_mac.sv
// ----------------------------------------------------------------------------
// qcap_mac: shared gain multiplier and product accumulator
// Multiplies a 32-bit gain by one 18-bit operand digit per cycle, sums the
// digit products and returns the product scaled down by 2^16 or 2^17.
// ----------------------------------------------------------------------------
module qcap_mac (
  input  logic                clk,
  input  qcap_pkg::gain_t     gain,
  input  qcap_pkg::dig_t      digit,
  input  qcap_pkg::mac_ctrl_t ctrl,
  output qcap_pkg::term_t     term_mag
);

  qcap_pkg::prod_t mul_r;
  qcap_pkg::pacc_t pacc_r;

  always_ff @(posedge clk) begin
    mul_r <= qcap_pkg::prod_t'(gain) * qcap_pkg::prod_t'(digit);
    if (ctrl.acc_en) begin
      if (ctrl.acc_hi) begin
        pacc_r <= pacc_r + (qcap_pkg::pacc_t'(mul_r) << qcap_pkg::DIG_W);
      end else begin
        pacc_r <= qcap_pkg::pacc_t'(mul_r);
      end
    end
  end

  // Dropping the low bits truncates the magnitude, which is truncation
  // toward zero once the sign is applied.
  assign term_mag = ctrl.sh17
                  ? qcap_pkg::term_t'(pacc_r[qcap_pkg::PACC_W-1:qcap_pkg::FRAC_W+1])
                  : pacc_r[qcap_pkg::PACC_W-1:qcap_pkg::FRAC_W];

endmodule

### rtl/core/quad_cascaded_attitude_pid_core.sv
// ----------------------------------------------------------------------------
// quad_cascaded_attitude_pid_core: cascaded attitude PID with X-layout mixer
// One sensor word in, one word of four motor commands out per control tick.
// ----------------------------------------------------------------------------
// Usage. Each word on in_word carries the pitch and roll angles, the three
// gyro rates and the throttle. It is taken when valid and ready are both high.
// in_word.ready is high only while the core is idle. One word on out_word
// carries the four saturated motor commands for that sample.
// The result word shows valid in the same cycle as the core returns to
// idle and can take the next word. The time per word is set by the single
// 32x18 multiplier: it works through thirteen gain products, three of which
// need two digits. The output word sits in a register, so the core may take
// and process the next sample while the last result waits. If that result
// is still not taken when the next one is finished, the core holds in its
// last step until out_word.ready is seen, and accepts nothing meanwhile.
// Reset (synchronous, rst_n low) restores the default gains and clears the
// integrals, the previous samples and any result in flight.
// Gains are written through the APB-style port at byte address 4*index.
// The user writes them only while the core is idle; it is not enforced.
// ----------------------------------------------------------------------------
module quad_cascaded_attitude_pid_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  qcap_in_if.sink                              in_word,
  qcap_out_if.source                           out_word,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [qcap_pkg::PADDR_W-1:0]         paddr,
  input  logic [qcap_pkg::PDATA_W-1:0]         pwdata,
  output logic [qcap_pkg::PDATA_W-1:0]         prdata,
  output logic                                 pready
);

  // Magnitude of a signed operand; the sign travels separately.
  function automatic qcap_pkg::mag_t mag_of(input qcap_pkg::opsum_t v);
    qcap_pkg::opsum_t a;
    a = v[qcap_pkg::OPS_W-1] ? -v : v;
    return qcap_pkg::mag_t'(a);
  endfunction

  // Running integral plus the new angle, clamped to the integral limit.
  function automatic qcap_pkg::integ_t clamp_int(input qcap_pkg::integ_t i,
                                                 input qcap_pkg::sample_t s);
    qcap_pkg::isum_t sum;
    qcap_pkg::isum_t lim;
    sum = qcap_pkg::isum_t'(i) + qcap_pkg::isum_t'(s);
    lim = qcap_pkg::isum_t'(qcap_pkg::INTEGRAL_LIMIT);
    if (sum > lim) begin
      sum = lim;
    end else if (sum < -lim) begin
      sum = -lim;
    end
    return qcap_pkg::integ_t'(sum);
  endfunction

  function automatic qcap_pkg::acc_t acc_step(input qcap_pkg::acc_t a,
                                              input qcap_pkg::acc_t t,
                                              input logic neg);
    return neg ? a - t : a + t;
  endfunction

  function automatic qcap_pkg::motor_t sat_motor(input qcap_pkg::mix_t s);
    qcap_pkg::motor_t m;
    if (s < 0) begin
      m = '0;
    end else if (s > qcap_pkg::mix_t'(qcap_pkg::MOTOR_MAX)) begin
      m = qcap_pkg::motor_t'(qcap_pkg::MOTOR_MAX);
    end else begin
      m = qcap_pkg::motor_t'(s);
    end
    return m;
  endfunction

  // Sequencer.
  qcap_pkg::state_t state_r, state_nxt;
  qcap_pkg::tidx_t  term_idx_r, term_idx_nxt;
  logic             dig_r, dig_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Gain registers.
  qcap_pkg::gain_t tilt_outer_kp_r, tilt_outer_ki_r, tilt_outer_kd_r, yaw_outer_kp_r;
  qcap_pkg::gain_t tilt_inner_kp_r, tilt_inner_kd_r, yaw_inner_kp_r, yaw_inner_kd_r;

  // Loop state carried from one tick to the next.
  qcap_pkg::integ_t  pitch_int_r, roll_int_r;
  qcap_pkg::sample_t last_pa_r, last_ra_r, last_gx_r, last_gy_r, last_gz_r;

  // Per-tick working registers.
  qcap_pkg::sample_t gx_r, gy_r, gz_r;
  qcap_pkg::motor_t  thr_r;
  qcap_pkg::mag_t    op_mag_r [qcap_pkg::NUM_TERMS];
  logic              op_neg_r [qcap_pkg::NUM_TERMS];
  qcap_pkg::acc_t    acc_p_r, acc_r_r, acc_y_r;
  qcap_pkg::opsum_t  sum_p_r, sum_r_r, sum_y_r;
  qcap_pkg::mix_t    mix_u_r, mix_v_r, mix_tp_r, mix_tm_r;
  qcap_pkg::motor_t  motor_0_r, motor_1_r, motor_2_r, motor_3_r;

  logic                 in_acc;
  logic                 cfg_wr;
  logic                 out_free;
  qcap_pkg::term_info_t cur_info, iss_info;
  qcap_pkg::tidx_t      iss_idx;
  logic                 iss_dig;
  qcap_pkg::mag_t       iss_mag;
  qcap_pkg::gain_t      iss_gain;
  qcap_pkg::dig_t       iss_digit;
  qcap_pkg::mac_ctrl_t  mac_ctrl;
  qcap_pkg::term_t      term_mag;
  qcap_pkg::acc_t       term_s;
  logic                 cur_neg;
  qcap_pkg::sample_t    pa, ra, gx, gy, gz;
  qcap_pkg::integ_t     pint_new, rint_new;

  assign in_word.ready = (state_r == qcap_pkg::ST_IDLE);
  assign in_acc        = in_word.valid && in_word.ready;
  assign out_free      = !out_valid_r || out_word.ready;
  assign pready        = 1'b1;
  assign cfg_wr        = psel && penable && pwrite;

  assign pa = in_word.pitch_angle;
  assign ra = in_word.roll_angle;
  assign gx = in_word.gyro_x;
  assign gy = in_word.gyro_y;
  assign gz = in_word.gyro_z;
  assign pint_new = clamp_int(pitch_int_r, pa);
  assign rint_new = clamp_int(roll_int_r, ra);

  // The multiplier is fed one step ahead: in the finishing step of one
  // product it already takes the first digit of the next.
  assign cur_info = qcap_pkg::term_info(term_idx_r);
  assign iss_idx  = (state_r == qcap_pkg::ST_FIN) ? term_idx_r + qcap_pkg::tidx_t'(1)
                                                  : term_idx_r;
  assign iss_dig  = (state_r == qcap_pkg::ST_ACC) && !dig_r;
  assign iss_info = qcap_pkg::term_info(iss_idx);
  assign iss_mag  = (iss_idx < qcap_pkg::tidx_t'(qcap_pkg::NUM_TERMS)) ? op_mag_r[iss_idx]
                                                                        : '0;
  assign iss_digit = iss_dig ? iss_mag[qcap_pkg::MAG_W-1:qcap_pkg::DIG_W]
                             : iss_mag[qcap_pkg::DIG_W-1:0];
  assign cur_neg  = op_neg_r[term_idx_r];
  assign term_s   = qcap_pkg::acc_t'(term_mag);

  assign mac_ctrl.acc_en = (state_r == qcap_pkg::ST_ACC);
  assign mac_ctrl.acc_hi = dig_r;
  assign mac_ctrl.sh17   = cur_info.sh17;

  always_comb begin
    unique case (iss_info.gain)
      qcap_pkg::REG_TILT_OUTER_KP: iss_gain = tilt_outer_kp_r;
      qcap_pkg::REG_TILT_OUTER_KI: iss_gain = tilt_outer_ki_r;
      qcap_pkg::REG_TILT_OUTER_KD: iss_gain = tilt_outer_kd_r;
      qcap_pkg::REG_YAW_OUTER_KP:  iss_gain = yaw_outer_kp_r;
      qcap_pkg::REG_TILT_INNER_KP: iss_gain = tilt_inner_kp_r;
      qcap_pkg::REG_TILT_INNER_KD: iss_gain = tilt_inner_kd_r;
      qcap_pkg::REG_YAW_INNER_KP:  iss_gain = yaw_inner_kp_r;
      qcap_pkg::REG_YAW_INNER_KD:  iss_gain = yaw_inner_kd_r;
    endcase
  end

  always_comb begin
    unique case (qcap_pkg::reg_idx_t'(paddr[qcap_pkg::PADDR_W-1:qcap_pkg::REG_LSB]))
      qcap_pkg::REG_TILT_OUTER_KP: prdata = tilt_outer_kp_r;
      qcap_pkg::REG_TILT_OUTER_KI: prdata = tilt_outer_ki_r;
      qcap_pkg::REG_TILT_OUTER_KD: prdata = tilt_outer_kd_r;
      qcap_pkg::REG_YAW_OUTER_KP:  prdata = yaw_outer_kp_r;
      qcap_pkg::REG_TILT_INNER_KP: prdata = tilt_inner_kp_r;
      qcap_pkg::REG_TILT_INNER_KD: prdata = tilt_inner_kd_r;
      qcap_pkg::REG_YAW_INNER_KP:  prdata = yaw_inner_kp_r;
      qcap_pkg::REG_YAW_INNER_KD:  prdata = yaw_inner_kd_r;
    endcase
  end

  qcap_mac u_mac (
    .clk      (clk),
    .gain     (iss_gain),
    .digit    (iss_digit),
    .ctrl     (mac_ctrl),
    .term_mag (term_mag)
  );

  // Sequence per tick: the seven angle-loop products, then the rate-loop
  // operands are formed from the angle-loop sums, then the six rate-loop
  // products, then the two mixing steps. Each product spends one or two
  // accumulate steps and one finishing step that adds the signed, truncated
  // result into its axis sum.
  always_comb begin
    state_nxt     = state_r;
    term_idx_nxt  = term_idx_r;
    dig_nxt       = dig_r;
    out_valid_nxt = out_valid_r;
    if (out_word.valid && out_word.ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      qcap_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt    = qcap_pkg::ST_MUL;
          term_idx_nxt = '0;
          dig_nxt      = 1'b0;
        end
      end
      qcap_pkg::ST_MUL: begin
        state_nxt = qcap_pkg::ST_ACC;
      end
      qcap_pkg::ST_ACC: begin
        if (cur_info.two_dig && !dig_r) begin
          dig_nxt = 1'b1;
        end else begin
          dig_nxt   = 1'b0;
          state_nxt = qcap_pkg::ST_FIN;
        end
      end
      qcap_pkg::ST_FIN: begin
        if (term_idx_r == qcap_pkg::tidx_t'(qcap_pkg::NUM_TERMS - 1)) begin
          state_nxt = qcap_pkg::ST_MIX1;
        end else begin
          term_idx_nxt = term_idx_r + qcap_pkg::tidx_t'(1);
          if (term_idx_r == qcap_pkg::tidx_t'(qcap_pkg::LAST_OUTER)) begin
            state_nxt = qcap_pkg::ST_OPND1;
          end else begin
            state_nxt = qcap_pkg::ST_ACC;
          end
        end
      end
      qcap_pkg::ST_OPND1: state_nxt = qcap_pkg::ST_OPND2;
      qcap_pkg::ST_OPND2: state_nxt = qcap_pkg::ST_MUL;
      qcap_pkg::ST_MIX1:  state_nxt = qcap_pkg::ST_MIX2;
      qcap_pkg::ST_MIX2: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = qcap_pkg::ST_IDLE;
        end
      end
    endcase
  end

  // Control, gains and loop state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= qcap_pkg::ST_IDLE;
      term_idx_r      <= '0;
      dig_r           <= 1'b0;
      out_valid_r     <= 1'b0;
      tilt_outer_kp_r <= qcap_pkg::RST_TILT_OUTER_KP;
      tilt_outer_ki_r <= qcap_pkg::RST_TILT_OUTER_KI;
      tilt_outer_kd_r <= qcap_pkg::RST_TILT_OUTER_KD;
      yaw_outer_kp_r  <= qcap_pkg::RST_YAW_OUTER_KP;
      tilt_inner_kp_r <= qcap_pkg::RST_TILT_INNER_KP;
      tilt_inner_kd_r <= qcap_pkg::RST_TILT_INNER_KD;
      yaw_inner_kp_r  <= qcap_pkg::RST_YAW_INNER_KP;
      yaw_inner_kd_r  <= qcap_pkg::RST_YAW_INNER_KD;
      pitch_int_r     <= '0;
      roll_int_r      <= '0;
      last_pa_r       <= '0;
      last_ra_r       <= '0;
      last_gx_r       <= '0;
      last_gy_r       <= '0;
      last_gz_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      term_idx_r  <= term_idx_nxt;
      dig_r       <= dig_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr) begin
        unique case (qcap_pkg::reg_idx_t'(paddr[qcap_pkg::PADDR_W-1:qcap_pkg::REG_LSB]))
          qcap_pkg::REG_TILT_OUTER_KP: tilt_outer_kp_r <= pwdata;
          qcap_pkg::REG_TILT_OUTER_KI: tilt_outer_ki_r <= pwdata;
          qcap_pkg::REG_TILT_OUTER_KD: tilt_outer_kd_r <= pwdata;
          qcap_pkg::REG_YAW_OUTER_KP:  yaw_outer_kp_r  <= pwdata;
          qcap_pkg::REG_TILT_INNER_KP: tilt_inner_kp_r <= pwdata;
          qcap_pkg::REG_TILT_INNER_KD: tilt_inner_kd_r <= pwdata;
          qcap_pkg::REG_YAW_INNER_KP:  yaw_inner_kp_r  <= pwdata;
          qcap_pkg::REG_YAW_INNER_KD:  yaw_inner_kd_r  <= pwdata;
        endcase
      end
      if (in_acc) begin
        pitch_int_r <= pint_new;
        roll_int_r  <= rint_new;
        last_pa_r   <= pa;
        last_ra_r   <= ra;
        last_gx_r   <= gx;
        last_gy_r   <= gy;
        last_gz_r   <= gz;
      end
    end
  end

  // Datapath registers. The pitch rate loop takes gyro_y and the roll rate
  // loop gyro_x, each against its own previous sample.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      gx_r  <= gx;
      gy_r  <= gy;
      gz_r  <= gz;
      thr_r <= in_word.throttle;
      op_mag_r[0]  <= mag_of(qcap_pkg::opsum_t'(pa));
      op_neg_r[0]  <= pa[qcap_pkg::SAMPLE_W-1];
      op_mag_r[1]  <= mag_of(qcap_pkg::opsum_t'(pint_new));
      op_neg_r[1]  <= pint_new[qcap_pkg::INT_W-1];
      op_mag_r[2]  <= mag_of(qcap_pkg::opsum_t'(pa) - qcap_pkg::opsum_t'(last_pa_r));
      op_neg_r[2]  <= (pa < last_pa_r);
      op_mag_r[3]  <= mag_of(qcap_pkg::opsum_t'(ra));
      op_neg_r[3]  <= ra[qcap_pkg::SAMPLE_W-1];
      op_mag_r[4]  <= mag_of(qcap_pkg::opsum_t'(rint_new));
      op_neg_r[4]  <= rint_new[qcap_pkg::INT_W-1];
      op_mag_r[5]  <= mag_of(qcap_pkg::opsum_t'(ra) - qcap_pkg::opsum_t'(last_ra_r));
      op_neg_r[5]  <= (ra < last_ra_r);
      op_mag_r[6]  <= mag_of(qcap_pkg::opsum_t'(gz));
      op_neg_r[6]  <= gz[qcap_pkg::SAMPLE_W-1];
      op_mag_r[10] <= mag_of(qcap_pkg::opsum_t'(gy) - qcap_pkg::opsum_t'(last_gy_r));
      op_neg_r[10] <= (gy < last_gy_r);
      op_mag_r[11] <= mag_of(qcap_pkg::opsum_t'(gx) - qcap_pkg::opsum_t'(last_gx_r));
      op_neg_r[11] <= (gx < last_gx_r);
      op_mag_r[12] <= mag_of(qcap_pkg::opsum_t'(gz) - qcap_pkg::opsum_t'(last_gz_r));
      op_neg_r[12] <= (gz < last_gz_r);
      acc_p_r <= '0;
      acc_r_r <= '0;
      acc_y_r <= '0;
    end

    if (state_r == qcap_pkg::ST_FIN) begin
      unique case (cur_info.axis)
        qcap_pkg::AXIS_PITCH: acc_p_r <= acc_step(acc_p_r, term_s, cur_neg);
        qcap_pkg::AXIS_ROLL:  acc_r_r <= acc_step(acc_r_r, term_s, cur_neg);
        qcap_pkg::AXIS_YAW:   acc_y_r <= acc_step(acc_y_r, term_s, cur_neg);
        default: ;
      endcase
    end

    // The 3.5 feed-forward is folded in exactly: the pitch and roll rate
    // operands are 2*angle_out + 7*gyro, and their products drop 17 bits.
    if (state_r == qcap_pkg::ST_OPND1) begin
      sum_p_r <= (qcap_pkg::opsum_t'(acc_p_r) <<< 1) + (qcap_pkg::opsum_t'(gy_r) <<< 3)
               - qcap_pkg::opsum_t'(gy_r);
      sum_r_r <= (qcap_pkg::opsum_t'(acc_r_r) <<< 1) + (qcap_pkg::opsum_t'(gx_r) <<< 3)
               - qcap_pkg::opsum_t'(gx_r);
      sum_y_r <= qcap_pkg::opsum_t'(acc_y_r) + qcap_pkg::opsum_t'(gz_r);
    end

    if (state_r == qcap_pkg::ST_OPND2) begin
      op_mag_r[7] <= mag_of(sum_p_r);
      op_neg_r[7] <= sum_p_r[qcap_pkg::OPS_W-1];
      op_mag_r[8] <= mag_of(sum_r_r);
      op_neg_r[8] <= sum_r_r[qcap_pkg::OPS_W-1];
      op_mag_r[9] <= mag_of(sum_y_r);
      op_neg_r[9] <= sum_y_r[qcap_pkg::OPS_W-1];
      acc_p_r <= '0;
      acc_r_r <= '0;
      acc_y_r <= '0;
    end

    // Axis outputs stay well inside 2^53, so no axis saturation is needed
    // ahead of the mix.
    if (state_r == qcap_pkg::ST_MIX1) begin
      mix_u_r  <= qcap_pkg::mix_t'(acc_p_r) + qcap_pkg::mix_t'(acc_r_r);
      mix_v_r  <= qcap_pkg::mix_t'(acc_p_r) - qcap_pkg::mix_t'(acc_r_r);
      mix_tp_r <= qcap_pkg::mix_t'(thr_r) + qcap_pkg::mix_t'(acc_y_r);
      mix_tm_r <= qcap_pkg::mix_t'(thr_r) - qcap_pkg::mix_t'(acc_y_r);
    end

    if ((state_r == qcap_pkg::ST_MIX2) && out_free) begin
      motor_0_r <= sat_motor(mix_tm_r + mix_u_r);
      motor_1_r <= sat_motor(mix_tp_r + mix_v_r);
      motor_2_r <= sat_motor(mix_tm_r - mix_u_r);
      motor_3_r <= sat_motor(mix_tp_r - mix_v_r);
    end
  end

  assign out_word.valid   = out_valid_r;
  assign out_word.motor_0 = motor_0_r;
  assign out_word.motor_1 = motor_1_r;
  assign out_word.motor_2 = motor_2_r;
  assign out_word.motor_3 = motor_3_r;

endmodule

### dv/qcap_motor_scoreboard_pkg.sv
// ----------------------------------------------------------------------------
// qcap_motor_scoreboard_pkg: motor command predictor and scoreboard
// Holds its own copy of the gains and loop state, works out the four motor
// commands of every accepted sensor word and checks the result words in order.
// ----------------------------------------------------------------------------
package qcap_motor_scoreboard_pkg;

  import qcap_pkg::*;

  // Axis outputs saturate here before mixing.
  localparam longint AXIS_LIMIT = 64'sd1 <<< 60;

  typedef struct packed {
    sample_t pitch_angle;
    sample_t roll_angle;
    sample_t gyro_x;
    sample_t gyro_y;
    sample_t gyro_z;
    motor_t  throttle;
  } sensor_word_t;

  typedef struct packed {
    motor_t motor_0;
    motor_t motor_1;
    motor_t motor_2;
    motor_t motor_3;
  } motor_word_t;

  class attitude_scoreboard;
    gain_t       gains [8];
    longint      pitch_integ;
    longint      roll_integ;
    longint      prev_pitch;
    longint      prev_roll;
    longint      prev_rate_x;
    longint      prev_rate_y;
    longint      prev_rate_z;
    motor_word_t motor_q [$];
    int          errors;

    function new();
      gains[REG_TILT_OUTER_KP] = RST_TILT_OUTER_KP;
      gains[REG_TILT_OUTER_KI] = RST_TILT_OUTER_KI;
      gains[REG_TILT_OUTER_KD] = RST_TILT_OUTER_KD;
      gains[REG_YAW_OUTER_KP]  = RST_YAW_OUTER_KP;
      gains[REG_TILT_INNER_KP] = RST_TILT_INNER_KP;
      gains[REG_TILT_INNER_KD] = RST_TILT_INNER_KD;
      gains[REG_YAW_INNER_KP]  = RST_YAW_INNER_KP;
      gains[REG_YAW_INNER_KD]  = RST_YAW_INNER_KD;
      pitch_integ = 0;
      roll_integ  = 0;
      prev_pitch  = 0;
      prev_roll   = 0;
      prev_rate_x = 0;
      prev_rate_y = 0;
      prev_rate_z = 0;
      errors      = 0;
    endfunction

    function void set_gain(reg_idx_t idx, gain_t value);
      gains[idx] = value;
    endfunction

    function int pending();
      return motor_q.size();
    endfunction

    static function longint clip(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Unsigned Q16.16 gain times a signed operand, shifted right by frac and
    // truncated toward zero. The full product is formed exactly.
    static function longint gain_mul(gain_t g, longint x, int unsigned frac);
      logic [127:0]    prod;
      longint unsigned mag;
      longint unsigned quo;
      mag  = (x < 0) ? -x : x;
      prod = 128'(g) * 128'(mag);
      quo  = 64'(prod >> frac);
      return (x < 0) ? -longint'(quo) : longint'(quo);
    endfunction

    static function motor_t to_motor(longint v);
      return motor_t'(clip(v, 0, MOTOR_MAX));
    endfunction

    function void note_sample(sensor_word_t s);
      longint      pa, ra, gx, gy, gz, thr;
      longint      pitch_out, roll_out, yaw_out;
      longint      pitch_cmd, roll_cmd, yaw_cmd;
      motor_word_t m;
      pa  = longint'($signed(s.pitch_angle));
      ra  = longint'($signed(s.roll_angle));
      gx  = longint'($signed(s.gyro_x));
      gy  = longint'($signed(s.gyro_y));
      gz  = longint'($signed(s.gyro_z));
      thr = longint'($unsigned(s.throttle));

      // The clamped integral is used in the same tick.
      pitch_integ = clip(pitch_integ + pa, -INTEGRAL_LIMIT, INTEGRAL_LIMIT);
      roll_integ  = clip(roll_integ + ra, -INTEGRAL_LIMIT, INTEGRAL_LIMIT);

      pitch_out = gain_mul(gains[REG_TILT_OUTER_KP], pa, FRAC_W)
                + gain_mul(gains[REG_TILT_OUTER_KI], pitch_integ, FRAC_W)
                + gain_mul(gains[REG_TILT_OUTER_KD], pa - prev_pitch, FRAC_W);
      roll_out  = gain_mul(gains[REG_TILT_OUTER_KP], ra, FRAC_W)
                + gain_mul(gains[REG_TILT_OUTER_KI], roll_integ, FRAC_W)
                + gain_mul(gains[REG_TILT_OUTER_KD], ra - prev_roll, FRAC_W);
      yaw_out   = gain_mul(gains[REG_YAW_OUTER_KP], gz, FRAC_W);

      // The 3.5 rate feed-forward is kept exact by doubling and one more shift.
      pitch_cmd = gain_mul(gains[REG_TILT_INNER_KP], 2 * pitch_out + 7 * gy, FRAC_W + 1)
                + gain_mul(gains[REG_TILT_INNER_KD], gy - prev_rate_y, FRAC_W);
      roll_cmd  = gain_mul(gains[REG_TILT_INNER_KP], 2 * roll_out + 7 * gx, FRAC_W + 1)
                + gain_mul(gains[REG_TILT_INNER_KD], gx - prev_rate_x, FRAC_W);
      yaw_cmd   = gain_mul(gains[REG_YAW_INNER_KP], yaw_out + gz, FRAC_W)
                + gain_mul(gains[REG_YAW_INNER_KD], gz - prev_rate_z, FRAC_W);

      pitch_cmd = clip(pitch_cmd, -AXIS_LIMIT, AXIS_LIMIT);
      roll_cmd  = clip(roll_cmd, -AXIS_LIMIT, AXIS_LIMIT);
      yaw_cmd   = clip(yaw_cmd, -AXIS_LIMIT, AXIS_LIMIT);

      prev_pitch  = pa;
      prev_roll   = ra;
      prev_rate_x = gx;
      prev_rate_y = gy;
      prev_rate_z = gz;

      m.motor_0 = to_motor(thr + roll_cmd + pitch_cmd - yaw_cmd);
      m.motor_1 = to_motor(thr - roll_cmd + pitch_cmd + yaw_cmd);
      m.motor_2 = to_motor(thr - roll_cmd - pitch_cmd - yaw_cmd);
      m.motor_3 = to_motor(thr + roll_cmd - pitch_cmd + yaw_cmd);
      motor_q.push_back(m);
    endfunction

    function void compare_field(string field, motor_t want, motor_t got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_motors(motor_word_t got);
      motor_word_t want;
      if (motor_q.size() == 0) begin
        $error("motor word %h arrived with no sensor word outstanding", got);
        errors++;
        return;
      end
      want = motor_q.pop_front();
      compare_field("motor_0", want.motor_0, got.motor_0);
      compare_field("motor_1", want.motor_1, got.motor_1);
      compare_field("motor_2", want.motor_2, got.motor_2);
      compare_field("motor_3", want.motor_3, got.motor_3);
    endfunction
  endclass

endpackage

### dv/quad_cascaded_attitude_pid_core_tb.sv
// ----------------------------------------------------------------------------
// quad_cascaded_attitude_pid_core_tb: testbench of the cascaded attitude core
// Drives sensor words in random bursts, stalls the motor word channel on a
// pattern of its own, and checks every motor word against a predictor. Gains
// are written and read back over the register port between phases.
// ----------------------------------------------------------------------------
module quad_cascaded_attitude_pid_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import qcap_pkg::*;
  import qcap_motor_scoreboard_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int NUM_REGS     = 8;
  // Long enough for a word to pass through the core, with margin on top.
  localparam int DRAIN_CYCLES = 40;
  // Ends a run that hangs; the limit lies well above the slowest correct run.
  localparam int TIMEOUT_NS   = 12_000_000;

  typedef gain_t gain_set_t [NUM_REGS];

  logic               clk = 1'b0;
  logic               rst_n;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  // Slowly wandering attitude used for the well-behaved part of the stimulus.
  int drift_pitch = 0;
  int drift_roll  = 0;

  qcap_in_if  in_word ();
  qcap_out_if out_word ();

  attitude_scoreboard sb = new();

  always #(CLK_PERIOD / 2) clk = ~clk;

  quad_cascaded_attitude_pid_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .out_word (out_word),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic sensor_word_t sample_of(int pa, int ra, int gx, int gy, int gz, int thr);
    sensor_word_t w;
    w.pitch_angle = sample_t'(pa);
    w.roll_angle  = sample_t'(ra);
    w.gyro_x      = sample_t'(gx);
    w.gyro_y      = sample_t'(gy);
    w.gyro_z      = sample_t'(gz);
    w.throttle    = motor_t'(thr);
    return w;
  endfunction

  function automatic int spread(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // The corners of a 16-bit field: both extremes, zero and plus or minus one.
  function automatic logic [15:0] corner_value();
    case ($urandom_range(0, 4))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'h0001;
    endcase
  endfunction

  // Most words are modest samples that keep the motors off their rails so the
  // loop arithmetic shows through; the rest is full-range noise and corners.
  function automatic sensor_word_t random_sample();
    sensor_word_t w;
    int           sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) begin
      w = sample_of(spread(600), spread(600), spread(3000), spread(3000), spread(3000),
                    $urandom_range(20000, 45000));
    end else if (sel < 6) begin
      w = sensor_word_t'({$urandom, $urandom, $urandom});
    end else if (sel == 6) begin
      w = sample_of(corner_value(), corner_value(), corner_value(), corner_value(),
                    corner_value(), corner_value());
    end else begin
      // A smooth trajectory keeps the derivatives small and lets the integrals
      // walk slowly into and out of their clamp.
      drift_pitch = int'(attitude_scoreboard::clip(drift_pitch + spread(64), -2000, 2000));
      drift_roll  = int'(attitude_scoreboard::clip(drift_roll + spread(64), -2000, 2000));
      w = sample_of(drift_pitch, drift_roll, spread(200), spread(200), spread(200),
                    $urandom_range(25000, 40000));
    end
    return w;
  endfunction

  function automatic gain_set_t moderate_gains();
    gain_set_t g;
    g[REG_TILT_OUTER_KP] = $urandom_range(0, 26214400);
    g[REG_TILT_OUTER_KI] = $urandom_range(0, 655360);
    g[REG_TILT_OUTER_KD] = $urandom_range(0, 6553600);
    g[REG_YAW_OUTER_KP]  = $urandom_range(0, 262144);
    g[REG_TILT_INNER_KP] = $urandom_range(0, 8192);
    g[REG_TILT_INNER_KD] = $urandom_range(0, 1024);
    g[REG_YAW_INNER_KP]  = $urandom_range(0, 8192);
    g[REG_YAW_INNER_KD]  = $urandom_range(0, 2048);
    return g;
  endfunction

  // --------------------------------------------------------------------------
  // Register port. Transfers run back to back, so psel stays high from one
  // to the next and is only dropped by the caller once a batch is done.
  // --------------------------------------------------------------------------

  task automatic reg_xfer(input logic wr, input reg_idx_t idx, input gain_t wdata,
                          output gain_t rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= PADDR_W'(int'(idx) << REG_LSB);
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
  endtask

  // Reads every gain back and compares it with the predictor's copy.
  task automatic check_gains();
    gain_t    rdata;
    reg_idx_t idx;
    for (int i = 0; i < NUM_REGS; i++) begin
      idx = reg_idx_t'(i);
      reg_xfer(1'b0, idx, '0, rdata);
      if (rdata !== sb.gains[idx]) begin
        $error("%s: expected %h, got %h", idx.name(), sb.gains[idx], rdata);
        sb.errors++;
      end
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Only called with the core idle: every sensor word sent so far has had
  // its motor word taken.
  task automatic load_gains(input gain_set_t g);
    gain_t    unused;
    reg_idx_t idx;
    for (int i = 0; i < NUM_REGS; i++) begin
      idx = reg_idx_t'(i);
      reg_xfer(1'b1, idx, g[i], unused);
      sb.set_gain(idx, g[i]);
    end
    check_gains();
  endtask

  // --------------------------------------------------------------------------
  // Sensor word sender. Words go out in bursts of random length; within a
  // burst valid stays high and only the payload changes. A phase ends once
  // every motor word it caused has been taken.
  // --------------------------------------------------------------------------

  task automatic send_words(ref sensor_word_t words[$]);
    int burst;
    int gap;
    burst = 0;
    foreach (words[i]) begin
      if (burst == 0) begin
        burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 12);
      end
      in_word.valid       <= 1'b1;
      in_word.pitch_angle <= words[i].pitch_angle;
      in_word.roll_angle  <= words[i].roll_angle;
      in_word.gyro_x      <= words[i].gyro_x;
      in_word.gyro_y      <= words[i].gyro_y;
      in_word.gyro_z      <= words[i].gyro_z;
      in_word.throttle    <= words[i].throttle;
      do @(posedge clk); while (!in_word.ready);
      sb.note_sample(words[i]);
      burst--;
      if (burst == 0 || i == words.size() - 1) begin
        in_word.valid <= 1'b0;
        gap = $urandom_range(1, 24);
        repeat (gap) @(posedge clk);
      end
    end
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic send_random(int count);
    sensor_word_t words[$];
    repeat (count) words.push_back(random_sample());
    send_words(words);
  endtask

  // --------------------------------------------------------------------------
  // Motor word receiver. Outputs are sampled at the clock edge, before any
  // update of that edge lands. Ready follows runs of random length: mostly
  // short stalls, now and then one long enough to make the core hold a
  // finished word, and now and then a long stretch with no stall at all.
  // --------------------------------------------------------------------------

  initial begin
    int run;
    bit level;
    run   = 0;
    level = 1'b0;
    out_word.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_word.valid && out_word.ready) begin
        sb.check_motors(motor_word_t'({out_word.motor_0, out_word.motor_1,
                                       out_word.motor_2, out_word.motor_3}));
      end
      if (run == 0) begin
        level = ($urandom_range(0, 2) != 0);
        if (level) begin
          run = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 400) : $urandom_range(1, 60);
        end else begin
          run = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 6);
        end
      end
      run--;
      out_word.ready <= level;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------

  initial begin
    gain_set_t    gains;
    sensor_word_t words[$];

    rst_n               <= 1'b0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    in_word.valid       <= 1'b0;
    in_word.pitch_angle <= '0;
    in_word.roll_angle  <= '0;
    in_word.gyro_x      <= '0;
    in_word.gyro_y      <= '0;
    in_word.gyro_z      <= '0;
    in_word.throttle    <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // The gains must come out of reset at their defaults.
    check_gains();
    send_random(150);

    // A tuned set with integral and derivative action, so the directed words
    // can show the integral clamp and the derivative extremes.
    gains                    = sb.gains;
    gains[REG_TILT_OUTER_KI] = 32'd131072;
    gains[REG_TILT_OUTER_KD] = 32'd1638400;
    load_gains(gains);

    words.push_back(sample_of(0, 0, 0, 0, 0, 0));
    words.push_back(sample_of(0, 0, 0, 0, 0, 65535));
    words.push_back(sample_of(0, 0, 0, 0, 0, 32768));
    // The integrals climb and then clamp, on pitch upward and on roll downward.
    words.push_back(sample_of(100, -100, 0, 0, 0, 32768));
    words.push_back(sample_of(150, -150, 0, 0, 0, 32768));
    words.push_back(sample_of(150, -150, 0, 0, 0, 32768));
    words.push_back(sample_of(150, -150, 0, 0, 0, 32768));
    // Full-scale angle swings: the integrals jump to the opposite clamp and
    // the angle derivative takes its widest step both ways.
    words.push_back(sample_of(-32768, 32767, 0, 0, 0, 32768));
    words.push_back(sample_of(32767, -32768, 0, 0, 0, 32768));
    // Full-scale rate swings exercise the feed-forward and rate derivative.
    words.push_back(sample_of(0, 0, 32767, -32768, 32767, 32768));
    words.push_back(sample_of(0, 0, -32768, 32767, -32768, 32768));
    words.push_back(sample_of(-1, 1, -1, 1, -1, 32768));
    words.push_back(sample_of(5, 5, 40, -40, 20, 30000));
    words.push_back(sample_of(-5, -5, -40, 40, -20, 30000));
    // Everything at one rail, then at the other: the motors saturate, some high and some low.
    words.push_back(sample_of(32767, 32767, 32767, 32767, 32767, 65535));
    words.push_back(sample_of(-32768, -32768, -32768, -32768, -32768, 0));
    words.push_back(sample_of(1, -1, 0, 0, 0, 1));
    words.push_back(sample_of(-300, 300, 100, 100, -100, 40000));
    words.push_back(sample_of(0, 0, 0, 0, 0, 0));
    send_words(words);
    send_random(300);

    gains = '{default: '1};
    load_gains(gains);
    send_random(100);

    // With no gain at all every motor simply follows the throttle.
    gains = '{default: '0};
    load_gains(gains);
    send_random(100);

    load_gains(moderate_gains());
    send_random(400);

    foreach (gains[i]) gains[i] = $urandom;
    load_gains(gains);
    send_random(100);

    load_gains(moderate_gains());
    send_random(100);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("quad_cascaded_attitude_pid_core verification clean");
    end else begin
      $display("quad_cascaded_attitude_pid_core verification failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("quad_cascaded_attitude_pid_core verification failed");
    $finish;
  end

endmodule

### filelist.f
rtl/core/qcap_pkg.sv
rtl/core/qcap_if.sv
rtl/core/qcap_mac.sv
rtl/core/quad_cascaded_attitude_pid_core.sv
dv/qcap_motor_scoreboard_pkg.sv
dv/quad_cascaded_attitude_pid_core_tb.sv
